// ===== rtl/irlp_pkg.sv =====
// ----------------------------------------------------------------------------
// irlp_pkg
// Shared types and character codes for the index range list parser.
// ----------------------------------------------------------------------------
package irlp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RES_FIFO_DEPTH  = 4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_START,
        PH_SEP,
        PH_FIRST_SIGN,
        PH_FIRST_NUM,
        PH_AFTER_FIRST,
        PH_DOTS,
        PH_MARKED,
        PH_SECOND_SIGN,
        PH_SECOND_NUM
    } phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } irlp_item_t;

    typedef struct packed {
        logic       room;
        logic [1:0] push_cnt;
    } irlp_push_t;

endpackage

// ===== rtl/irlp_in_stage.sv =====
// ----------------------------------------------------------------------------
// irlp_in_stage
// Input register holding one text item until the parser takes it.
// ----------------------------------------------------------------------------
module irlp_in_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // text_byte
    input  logic                   s_axis_tlast,   // end_of_text
    output logic                   item_valid,
    output irlp_pkg::irlp_item_t   item,
    input  logic                   item_take
);
    import irlp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    irlp_item_t item_reg;
    logic       accept;

    assign s_axis_tready = !valid_reg || item_take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.text_byte   <= s_axis_tdata;
            item_reg.end_of_text <= s_axis_tlast;
        end
    end

endmodule

// ===== rtl/irlp_core.sv =====
// ----------------------------------------------------------------------------
// irlp_core
// Parser state machine: one character per cycle while the result queue has room, up to two results out.
// ----------------------------------------------------------------------------
module irlp_core
#(
    parameter int VALUE_WIDTH = irlp_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       item_valid,
    input  irlp_pkg::irlp_item_t       item,
    output logic                       item_take,
    input  logic                       room,
    output logic [1:0]                 push_cnt,
    output logic [2*VALUE_WIDTH+2:0]   res0,
    output logic [2*VALUE_WIDTH+2:0]   res1
);
    import irlp_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int RES_W = 2 * VW + 3;
    localparam logic [VW-1:0] CAP = {1'b1, {(VW-1){1'b0}}};

    phase_t         phase_reg,  phase_next;
    logic [VW-1:0]  accum_reg,  accum_next;
    logic           neg_reg,    neg_next;
    logic [VW-1:0]  held_reg,   held_next;
    logic           any_reg,    any_next;
    logic           err_reg,    err_next;
    logic           one_based_reg;

    logic [7:0]     c;
    logic           c_space;
    logic           c_digit;
    logic           c_sign;
    logic           c_neg;
    logic [3:0]     dig;
    logic [VW+3:0]  prod;
    logic [VW-1:0]  acc_dig;
    logic [VW-1:0]  pos_sat;
    logic [VW-1:0]  fin;

    function automatic logic [RES_W-1:0] pack_res(input logic kind, input logic [VW-1:0] a,
                                                  input logic [VW-1:0] b, input logic perr,
                                                  input logic last);
        return {last, kind, perr, b, a};
    endfunction

    assign c       = item.text_byte;
    assign c_space = c inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign c_digit = c inside {[CH_ZERO:CH_NINE]};
    assign c_sign  = (c == CH_MINUS) || (c == CH_PLUS);
    assign c_neg   = (c == CH_MINUS);
    assign dig     = 4'(c - CH_ZERO);

    // times ten plus digit, saturated at the magnitude cap
    assign prod    = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1) + (VW+4)'(dig);
    assign acc_dig = (prod > (VW+4)'(CAP)) ? CAP : prod[VW-1:0];

    assign pos_sat = (accum_reg >= CAP) ? (CAP - VW'(1)) : accum_reg;
    assign fin     = neg_reg ? (VW'(0) - accum_reg)
                   : ((one_based_reg && (pos_sat != '0)) ? (pos_sat - VW'(1)) : pos_sat);

    assign item_take = item_valid && room;

    always_comb
    begin
        phase_t        ph;
        logic [VW-1:0] held_v;
        logic [VW-1:0] pa;
        logic [VW-1:0] pb;
        logic          pair_v;
        logic          err_v;

        phase_next = phase_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;
        held_next  = held_reg;
        any_next   = any_reg;
        err_next   = err_reg;
        push_cnt   = 2'd0;
        res0       = '0;
        res1       = '0;
        ph         = phase_reg;
        held_v     = held_reg;
        pa         = held_reg;
        pb         = held_reg;
        pair_v     = 1'b0;
        err_v      = err_reg;

        if (item_take)
        begin
            if (item.end_of_text)
            begin
                if (!err_reg)
                begin
                    case (phase_reg)
                        PH_START, PH_SEP:
                        begin
                        end
                        PH_FIRST_NUM:
                        begin
                            pair_v = 1'b1;
                            pa     = fin;
                            pb     = fin;
                        end
                        PH_AFTER_FIRST:
                        begin
                            pair_v = 1'b1;
                        end
                        PH_SECOND_NUM:
                        begin
                            pair_v = 1'b1;
                            pb     = fin;
                        end
                        default:
                        begin
                            err_v = 1'b1;
                        end
                    endcase
                end
                if (pair_v)
                begin
                    res0     = pack_res(KIND_PAIR, pa, pb, 1'b0, 1'b0);
                    res1     = pack_res(KIND_STATUS, '0, '0, err_v || !(any_reg || pair_v),
                                        1'b1);
                    push_cnt = 2'd2;
                end
                else
                begin
                    res0     = pack_res(KIND_STATUS, '0, '0, err_v || !any_reg, 1'b1);
                    push_cnt = 2'd1;
                end
                phase_next = PH_START;
                accum_next = '0;
                neg_next   = 1'b0;
                held_next  = '0;
                any_next   = 1'b0;
                err_next   = 1'b0;
            end
            else if (!err_reg)
            begin
                // close a finished number or marker, then consume the character
                if ((ph == PH_FIRST_NUM) && !c_digit)
                begin
                    held_v = fin;
                    ph     = PH_AFTER_FIRST;
                end
                if ((ph == PH_AFTER_FIRST) && !(c_space || (c == CH_MINUS) ||
                                               (c == CH_COLON) || (c == CH_DOT)))
                begin
                    pair_v = 1'b1;
                    pa     = held_v;
                    pb     = held_v;
                    ph     = PH_SEP;
                end
                if ((ph == PH_SECOND_NUM) && !c_digit)
                begin
                    pair_v = 1'b1;
                    pa     = held_reg;
                    pb     = fin;
                    ph     = PH_SEP;
                end
                if ((ph == PH_DOTS) && (c != CH_DOT))
                begin
                    ph = PH_MARKED;
                end

                held_next = held_v;
                if (pair_v)
                begin
                    res0     = pack_res(KIND_PAIR, pa, pb, 1'b0, 1'b1);
                    push_cnt = 2'd1;
                    any_next = 1'b1;
                end

                phase_next = ph;
                case (ph)
                    PH_START, PH_SEP:
                    begin
                        if (c_space || ((c == CH_COMMA) && (ph == PH_SEP)))
                        begin
                        end
                        else if (c_sign)
                        begin
                            accum_next = '0;
                            neg_next   = c_neg;
                            phase_next = PH_FIRST_SIGN;
                        end
                        else if (c_digit)
                        begin
                            accum_next = VW'(dig);
                            neg_next   = 1'b0;
                            phase_next = PH_FIRST_NUM;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_FIRST_SIGN, PH_SECOND_SIGN:
                    begin
                        if (c_digit)
                        begin
                            accum_next = acc_dig;
                            phase_next = (ph == PH_FIRST_SIGN) ? PH_FIRST_NUM : PH_SECOND_NUM;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_FIRST_NUM, PH_SECOND_NUM:
                    begin
                        accum_next = acc_dig;
                    end
                    PH_AFTER_FIRST:
                    begin
                        if ((c == CH_MINUS) || (c == CH_COLON))
                        begin
                            phase_next = PH_MARKED;
                        end
                        else if (c == CH_DOT)
                        begin
                            phase_next = PH_DOTS;
                        end
                    end
                    PH_DOTS:
                    begin
                    end
                    PH_MARKED:
                    begin
                        if (c_space)
                        begin
                        end
                        else if (c_sign)
                        begin
                            accum_next = '0;
                            neg_next   = c_neg;
                            phase_next = PH_SECOND_SIGN;
                        end
                        else if (c_digit)
                        begin
                            accum_next = VW'(dig);
                            neg_next   = 1'b0;
                            phase_next = PH_SECOND_NUM;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            accum_reg     <= '0;
            neg_reg       <= 1'b0;
            held_reg      <= '0;
            any_reg       <= 1'b0;
            err_reg       <= 1'b0;
            one_based_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
            held_reg  <= held_next;
            any_reg   <= any_next;
            err_reg   <= err_next;
            if (cfg_wr_en)
            begin
                one_based_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== rtl/irlp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// irlp_res_fifo
// Small result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
module irlp_res_fifo
#(
    parameter int WIDTH = 2 * irlp_pkg::VALUE_WIDTH_DEF + 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_cnt,
    input  logic [WIDTH-1:0]     wr0,
    input  logic [WIDTH-1:0]     wr1,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WIDTH-1:0]     m_data
);
    import irlp_pkg::*;

    localparam int DEPTH = RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_inc;

    assign m_valid    = (count_reg != '0);
    assign m_data     = mem[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_inc] <= wr1;
        end
    end

endmodule

// ===== rtl/index_range_list_parser_unit.sv =====
// ----------------------------------------------------------------------------
// index_range_list_parser_unit: range list text to (first, second) pairs
// results pass input register then result queue; one character a cycle
// throughput while the queue has room, set by parser update and drain rate
// asynchronous active-low reset clears parser state, one_based and the queue
// ----------------------------------------------------------------------------
module index_range_list_parser_unit
#(
    parameter int VALUE_WIDTH = irlp_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic                                    cfg_wr_data,    // one_based
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [7:0]                              s_axis_tdata,   // text_byte
    input  logic                                    s_axis_tlast,   // end_of_text
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // range_first, range_second, parse_error, zero fill
    output logic [((2*VALUE_WIDTH+8)/8)*8-1:0]      m_axis_tdata,
    output logic                                    m_axis_tuser,   // result_kind
    output logic                                    m_axis_tlast    // last_of_item
);
    import irlp_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int RES_W  = 2 * VW + 3;
    localparam int DATA_W = ((2 * VW + 8) / 8) * 8;

    logic             item_valid;
    irlp_item_t       item;
    logic             item_take;
    logic             room;
    logic [1:0]       push_cnt;
    logic [RES_W-1:0] res0;
    logic [RES_W-1:0] res1;
    logic [RES_W-1:0] out_res;

    irlp_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    irlp_core #(.VALUE_WIDTH(VW)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .room        (room),
        .push_cnt    (push_cnt),
        .res0        (res0),
        .res1        (res1)
    );

    irlp_res_fifo #(.WIDTH(RES_W)) u_res_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .wr0      (res0),
        .wr1      (res1),
        .room     (room),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (out_res)
    );

    assign m_axis_tdata = DATA_W'(out_res[2*VW:0]);
    assign m_axis_tuser = out_res[2*VW+1];
    assign m_axis_tlast = out_res[2*VW+2];

endmodule

// ===== verif/index_range_list_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// index_range_list_parser_unit_tb
// Feeds range list texts one character per transfer and checks every pair
// and status result against an in-bench parser model, under both index
// modes and three patterns of sender and receiver back-pressure.
// ----------------------------------------------------------------------------
module index_range_list_parser_unit_tb;

    import irlp_pkg::*;

    localparam int VW         = VALUE_WIDTH_DEF;
    localparam int DW         = ((2*VW+8)/8)*8;
    localparam int PHASE_ITEMS = 450;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic          kind;
        logic [VW-1:0] first;
        logic [VW-1:0] second;
        logic          err;
        logic          last;
    } range_result_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic            cfg_wr_data = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [7:0]      s_axis_tdata = 8'h00;
    logic            s_axis_tlast = 1'b0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [DW-1:0]   m_axis_tdata;
    logic            m_axis_tuser;
    logic            m_axis_tlast;

    irlp_item_t      pending_chars[$];
    range_result_t   expected_results[$];
    logic [7:0]      text_buf[$];

    int unsigned     src_idle_pct = 26;
    int unsigned     snk_idle_pct = 67;
    logic            char_taken = 1'b0;
    int unsigned     stall_cycles = 0;

    int unsigned     fail_count = 0;
    int unsigned     chars_in = 0;
    int unsigned     pairs_checked = 0;
    int unsigned     status_checked = 0;
    int unsigned     invalid_checked = 0;

    // parser model state
    logic            mode_one_based = 1'b0;
    phase_t          parse_ph = PH_START;
    logic [63:0]     num_mag = 64'd0;
    logic            num_neg = 1'b0;
    logic [VW-1:0]   held_bound = '0;
    logic            pair_seen = 1'b0;
    logic            err_seen = 1'b0;

    index_range_list_parser_unit #(
        .VALUE_WIDTH (VW)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic void push_digit(input logic [7:0] c);
        logic [63:0] cap;
        logic [63:0] d;
        cap = 64'd1 << (VW - 1);
        d   = {56'd0, c - CH_ZERO};
        if (num_mag > (cap - d) / 64'd10)
            num_mag = cap;
        else
            num_mag = num_mag * 64'd10 + d;
    endfunction

    function automatic logic [VW-1:0] close_number();
        logic [63:0] cap;
        logic [63:0] v;
        cap = 64'd1 << (VW - 1);
        if (num_neg)
        begin
            v = 64'd0 - num_mag;
        end
        else
        begin
            v = (num_mag > cap - 64'd1) ? cap - 64'd1 : num_mag;
            if (mode_one_based && v != 64'd0)
                v = v - 64'd1;
        end
        return v[VW-1:0];
    endfunction

    function automatic void add_result(input logic kind, input logic [VW-1:0] a,
                                       input logic [VW-1:0] b, input logic err);
        range_result_t r;
        r.kind   = kind;
        r.first  = a;
        r.second = b;
        r.err    = err;
        r.last   = 1'b0;
        expected_results.push_back(r);
        if (kind == KIND_PAIR)
            pair_seen = 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        bit settled;
        settled = 1'b0;
        while (!settled)
        begin
            settled = 1'b1;
            case (parse_ph)
                PH_START, PH_SEP:
                begin
                    if (is_blank(c) || (c == CH_COMMA && parse_ph == PH_SEP))
                    begin
                    end
                    else if (c == CH_MINUS || c == CH_PLUS)
                    begin
                        num_mag  = 64'd0;
                        num_neg  = (c == CH_MINUS);
                        parse_ph = PH_FIRST_SIGN;
                    end
                    else if (is_digit(c))
                    begin
                        num_mag  = 64'd0;
                        num_neg  = 1'b0;
                        push_digit(c);
                        parse_ph = PH_FIRST_NUM;
                    end
                    else
                    begin
                        err_seen = 1'b1;
                    end
                end
                PH_FIRST_SIGN, PH_SECOND_SIGN:
                begin
                    if (is_digit(c))
                    begin
                        push_digit(c);
                        parse_ph = (parse_ph == PH_FIRST_SIGN) ? PH_FIRST_NUM : PH_SECOND_NUM;
                    end
                    else
                    begin
                        err_seen = 1'b1;
                    end
                end
                PH_FIRST_NUM:
                begin
                    if (is_digit(c))
                    begin
                        push_digit(c);
                    end
                    else
                    begin
                        held_bound = close_number();
                        parse_ph   = PH_AFTER_FIRST;
                        settled    = 1'b0;
                    end
                end
                PH_AFTER_FIRST:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (c == CH_MINUS || c == CH_COLON)
                    begin
                        parse_ph = PH_MARKED;
                    end
                    else if (c == CH_DOT)
                    begin
                        parse_ph = PH_DOTS;
                    end
                    else
                    begin
                        add_result(KIND_PAIR, held_bound, held_bound, 1'b0);
                        parse_ph = PH_SEP;
                        settled  = 1'b0;
                    end
                end
                PH_DOTS:
                begin
                    if (c != CH_DOT)
                    begin
                        parse_ph = PH_MARKED;
                        settled  = 1'b0;
                    end
                end
                PH_MARKED:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (c == CH_MINUS || c == CH_PLUS)
                    begin
                        num_mag  = 64'd0;
                        num_neg  = (c == CH_MINUS);
                        parse_ph = PH_SECOND_SIGN;
                    end
                    else if (is_digit(c))
                    begin
                        num_mag  = 64'd0;
                        num_neg  = 1'b0;
                        push_digit(c);
                        parse_ph = PH_SECOND_NUM;
                    end
                    else
                    begin
                        err_seen = 1'b1;
                    end
                end
                PH_SECOND_NUM:
                begin
                    if (is_digit(c))
                    begin
                        push_digit(c);
                    end
                    else
                    begin
                        add_result(KIND_PAIR, held_bound, close_number(), 1'b0);
                        parse_ph = PH_SEP;
                        settled  = 1'b0;
                    end
                end
                default:
                begin
                    err_seen = 1'b1;
                end
            endcase
        end
    endfunction

    function automatic void predict_ranges(input irlp_item_t it);
        int unsigned   n_before;
        range_result_t r;
        n_before = expected_results.size();
        if (it.end_of_text)
        begin
            if (!err_seen)
            begin
                case (parse_ph)
                    PH_START, PH_SEP:
                    begin
                    end
                    PH_FIRST_NUM:
                    begin
                        held_bound = close_number();
                        add_result(KIND_PAIR, held_bound, held_bound, 1'b0);
                    end
                    PH_AFTER_FIRST:
                        add_result(KIND_PAIR, held_bound, held_bound, 1'b0);
                    PH_SECOND_NUM:
                        add_result(KIND_PAIR, held_bound, close_number(), 1'b0);
                    default:
                        err_seen = 1'b1;
                endcase
            end
            add_result(KIND_STATUS, '0, '0, err_seen || !pair_seen);
            parse_ph   = PH_START;
            num_mag    = 64'd0;
            num_neg    = 1'b0;
            held_bound = '0;
            pair_seen  = 1'b0;
            err_seen   = 1'b0;
        end
        else if (!err_seen)
        begin
            parse_char(it.text_byte);
        end
        if (expected_results.size() > n_before)
        begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    // sampling, prediction and checking
    always @(posedge clk)
    begin
        range_result_t exp_r;
        logic          s_fire;
        logic          m_fire;
        s_fire = rst_n && s_axis_tvalid && s_axis_tready;
        m_fire = rst_n && m_axis_tvalid && m_axis_tready;
        char_taken <= s_fire;
        if (rst_n && cfg_wr_en)
            mode_one_based = cfg_wr_data;
        if (s_fire)
        begin
            chars_in++;
            predict_ranges('{text_byte: s_axis_tdata, end_of_text: s_axis_tlast});
        end
        if (m_fire)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: kind %0b data %h", m_axis_tuser, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tuser !== exp_r.kind)
                begin
                    $error("result_kind: expected %0b, got %0b", exp_r.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[VW-1:0] !== exp_r.first)
                begin
                    $error("range_first: expected %0d, got %0d",
                           $signed(exp_r.first), $signed(m_axis_tdata[VW-1:0]));
                    fail_count++;
                end
                if (m_axis_tdata[2*VW-1:VW] !== exp_r.second)
                begin
                    $error("range_second: expected %0d, got %0d",
                           $signed(exp_r.second), $signed(m_axis_tdata[2*VW-1:VW]));
                    fail_count++;
                end
                if (m_axis_tdata[2*VW] !== exp_r.err)
                begin
                    $error("parse_error: expected %0b, got %0b", exp_r.err, m_axis_tdata[2*VW]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_r.last)
                begin
                    $error("last_of_item: expected %0b, got %0b", exp_r.last, m_axis_tlast);
                    fail_count++;
                end
                if (exp_r.kind == KIND_STATUS)
                begin
                    status_checked++;
                    if (exp_r.err)
                        invalid_checked++;
                end
                else
                begin
                    pairs_checked++;
                end
            end
        end
        if (!rst_n || s_fire || m_fire || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // character driver
    always @(negedge clk)
    begin
        if (char_taken && pending_chars.size() != 0)
            void'(pending_chars.pop_front());
        if (s_axis_tvalid && !char_taken)
        begin
            s_axis_tvalid <= 1'b1;
        end
        else if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pending_chars[0].text_byte;
            s_axis_tlast  <= pending_chars[0].end_of_text;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic set_one_based(input logic v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'($urandom);
    endtask

    task automatic wait_results_settled();
        while (pending_chars.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back('{text_byte: s[i], end_of_text: 1'b0});
        pending_chars.push_back('{text_byte: 8'($urandom), end_of_text: 1'b1});
    endtask

    task automatic add_blanks();
        int unsigned k;
        k = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (k)
        begin
            case ($urandom_range(7))
                0:       text_buf.push_back(CH_TAB);
                1:       text_buf.push_back(CH_TAB + 8'($urandom_range(1, 4)));
                default: text_buf.push_back(CH_SPACE);
            endcase
        end
    endtask

    task automatic add_number();
        int unsigned r;
        int unsigned n_dig;
        r = $urandom_range(99);
        if (r < 15)
            text_buf.push_back(CH_MINUS);
        else if (r < 30)
            text_buf.push_back(CH_PLUS);
        n_dig = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
        repeat (n_dig)
            text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // one text of random content, mostly well formed; returns items queued, end-of-text item included
    task automatic queue_random_text(output int unsigned n_items);
        int unsigned shape;
        int unsigned n_ent;
        text_buf.delete();
        shape = $urandom_range(99);
        if (shape < 82)
        begin
            n_ent = $urandom_range(1, 4);
            for (int e = 0; e < n_ent; e++)
            begin
                add_blanks();
                if (e > 0)
                begin
                    case ($urandom_range(4))
                        0:       text_buf.push_back(CH_SPACE);
                        1:
                        begin
                            text_buf.push_back(CH_COMMA);
                            text_buf.push_back(CH_COMMA);
                        end
                        default: text_buf.push_back(CH_COMMA);
                    endcase
                    add_blanks();
                end
                add_number();
                if ($urandom_range(1) == 1)
                begin
                    add_blanks();
                    case ($urandom_range(2))
                        0:       text_buf.push_back(CH_MINUS);
                        1:       text_buf.push_back(CH_COLON);
                        default: repeat ($urandom_range(1, 3)) text_buf.push_back(CH_DOT);
                    endcase
                    add_blanks();
                    add_number();
                end
            end
            add_blanks();
            if (shape >= 70)
            begin
                // broken text: stray byte or cut short
                if ($urandom_range(1) == 0)
                    text_buf.insert($urandom_range(text_buf.size()), 8'($urandom));
                else
                    repeat ($urandom_range(1, text_buf.size())) void'(text_buf.pop_back());
            end
        end
        else if (shape < 88)
        begin
            add_blanks();
        end
        else
        begin
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom));
        end
        foreach (text_buf[i])
            pending_chars.push_back('{text_byte: text_buf[i], end_of_text: 1'b0});
        pending_chars.push_back('{text_byte: 8'($urandom), end_of_text: 1'b1});
        n_items = text_buf.size() + 1;
    endtask

    task automatic run_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                    input logic mode);
        int unsigned queued;
        int unsigned n;
        wait_results_settled();
        set_one_based(mode);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        queued = 0;
        while (queued < PHASE_ITEMS)
        begin
            queue_random_text(n);
            queued += n;
            // hold the sender back until the result queue has drained
            if ($urandom_range(19) == 0)
                wait_results_settled();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_one_based(1'b0);
        queue_text("9:-12");
        queue_text(",1");
        queue_text("5..+0\t7");
        queue_text("");
        queue_text("3-");
        wait_results_settled();
        set_one_based(1'b1);
        queue_text("1x");
        queue_text("2");

        run_random_phase(26, 67, 1'b0);
        run_random_phase(67, 26, 1'b1);
        run_random_phase(0, 0, 1'($urandom));
        wait_results_settled();

        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("covered %0d characters in both index modes under three stall patterns",
                 chars_in);
        $display("checked %0d range pairs and %0d status results, %0d of them invalid texts",
                 pairs_checked, status_checked, invalid_checked);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
